// File: design/mstq_pkg.sv
// types and constants shared by the timer queue modules
`default_nettype none
package mstq_pkg;

   typedef enum logic [2:0] {
      OP_ADD_ONE  = 3'd0,
      OP_ADD_PER  = 3'd1,
      OP_MODIFY   = 3'd2,
      OP_REMOVE   = 3'd3,
      OP_ENABLE   = 3'd4,
      OP_DISABLE  = 3'd5,
      OP_CLEAR    = 3'd6,
      OP_TICK     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  slot_id;
      logic [31:0] interval;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [3:0] timer_slot;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      EX_IDLE  = 2'd0,
      EX_CMD   = 2'd1,
      EX_SCAN  = 2'd2
   } ex_state_type;

endpackage
`default_nettype wire

// File: design/mstq_fifo.sv
// small register queue between the front and the back of the timer block
`default_nettype none
module mstq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   property p_count_bound;
      @(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(DEPTH);
   endproperty
   a_count_bound: assert property (p_count_bound) else $error("fifo overfilled");

   property p_push_grows;
      @(posedge clock) disable iff (reset)
         (do_push && !do_pop) |=> !empty;
   endproperty
   a_push_grows: assert property (p_push_grows) else $error("fifo lost a push");

   property p_pop_shrinks;
      @(posedge clock) disable iff (reset)
         (do_pop && !do_push && cnt_ff == (AW+1)'(1)) |=> empty;
   endproperty
   a_pop_shrinks: assert property (p_pop_shrinks) else $error("fifo count wrong");
endmodule
`default_nettype wire

// File: design/mstq_engine.sv
// back part: slot table, command execution and tick scan
`default_nettype none
module mstq_engine
   import mstq_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire req_type cmd,
   output logic         cmd_take,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_full
);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   ex_state_type          state_ff, state_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in, en_ff, en_in, per_ff, per_in;
   logic [TIME_WIDTH-1:0] ival_ff [SLOT_COUNT];
   logic [TIME_WIDTH-1:0] dl_ff [SLOT_COUNT];
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   req_type               cur_ff, cur_in;
   logic [SW-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [SW-1:0]         pslot_ff, pslot_in;

   logic [SW-1:0]         free_idx;
   logic                  free_ok;
   logic                  sid_ok, valid_slot;
   logic [SW-1:0]         sid;
   logic                  wr_en;
   logic [SW-1:0]         wr_idx;
   logic [TIME_WIDTH-1:0] wr_ival, wr_dl;
   logic                  wr_ival_en;
   logic [TIME_WIDTH-1:0] cur_ival, diff;
   logic                  due, scan_last;

   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign sid_ok     = ({28'd0, cur_ff.slot_id} < 32'(SLOT_COUNT));
   assign sid        = SW'(cur_ff.slot_id);
   assign valid_slot = sid_ok && used_ff[sid];
   assign cur_ival   = TIME_WIDTH'({32'd0, cur_ff.interval});
   assign diff       = now_ff - dl_ff[scan_ff];
   assign due        = used_ff[scan_ff] && en_ff[scan_ff] && !diff[TIME_WIDTH-1];
   assign scan_last  = (scan_ff == SW'(SLOT_COUNT - 1));
   assign cmd_take   = (state_ff == EX_IDLE) && cmd_valid;

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      en_in      = en_ff;
      per_in     = per_ff;
      now_in     = now_ff;
      cur_in     = cur_ff;
      scan_in    = scan_ff;
      pend_in    = pend_ff;
      pslot_in   = pslot_ff;
      wr_en      = 1'b0;
      wr_ival_en = 1'b0;
      wr_idx     = sid;
      wr_ival    = cur_ival;
      wr_dl      = now_ff + cur_ival;
      out_valid  = 1'b0;
      out_data   = '0;
      unique case (state_ff)
         EX_IDLE: begin
            if (cmd_valid) begin
               cur_in = cmd;
               if (op_type'(cmd.op) == OP_TICK) begin
                  now_in   = now_ff + 1'b1;
                  scan_in  = '0;
                  pend_in  = 1'b0;
                  state_in = EX_SCAN;
               end else begin
                  state_in = EX_CMD;
               end
            end
         end
         EX_CMD: begin
            out_valid     = 1'b1;
            out_data.kind = KIND_ACK;
            out_data.last = 1'b1;
            case (op_type'(cur_ff.op))
               OP_ADD_ONE, OP_ADD_PER: begin
                  out_data.status     = free_ok ? ST_OK : ST_FULL;
                  out_data.timer_slot = free_ok ? 4'(free_idx) : 4'd0;
               end
               OP_CLEAR: begin
                  out_data.status     = ST_OK;
                  out_data.timer_slot = 4'd0;
               end
               default: begin
                  out_data.status     = valid_slot ? ST_OK : ST_NO_SLOT;
                  out_data.timer_slot = cur_ff.slot_id;
               end
            endcase
            if (!out_full) begin
               state_in = EX_IDLE;
               case (op_type'(cur_ff.op))
                  OP_ADD_ONE, OP_ADD_PER: begin
                     if (free_ok) begin
                        used_in[free_idx] = 1'b1;
                        en_in[free_idx]   = 1'b1;
                        per_in[free_idx]  = (op_type'(cur_ff.op) == OP_ADD_PER);
                        wr_en      = 1'b1;
                        wr_ival_en = 1'b1;
                        wr_idx     = free_idx;
                     end
                  end
                  OP_MODIFY: begin
                     wr_en      = valid_slot;
                     wr_ival_en = valid_slot;
                  end
                  OP_REMOVE: begin
                     if (valid_slot) begin
                        used_in[sid] = 1'b0;
                        en_in[sid]   = 1'b0;
                        per_in[sid]  = 1'b0;
                     end
                  end
                  OP_ENABLE: begin
                     if (valid_slot && !en_ff[sid]) begin
                        en_in[sid] = 1'b1;
                        wr_en      = 1'b1;
                        wr_dl      = now_ff + ival_ff[sid];
                     end
                  end
                  OP_DISABLE: begin
                     if (valid_slot) begin
                        en_in[sid] = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     used_in = '0;
                     en_in   = '0;
                     per_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         EX_SCAN: begin
            // hold one found expiry back until the next is known, to mark last
            if (!(due && pend_ff && out_full)) begin
               if (due) begin
                  if (pend_ff) begin
                     out_valid           = 1'b1;
                     out_data.kind       = KIND_EXPIRY;
                     out_data.status     = ST_OK;
                     out_data.timer_slot = 4'(pslot_ff);
                     out_data.last       = 1'b0;
                  end
                  pend_in  = 1'b1;
                  pslot_in = scan_ff;
                  if (per_ff[scan_ff]) begin
                     wr_en  = 1'b1;
                     wr_idx = scan_ff;
                     wr_dl  = now_ff + ival_ff[scan_ff];
                  end else begin
                     used_in[scan_ff] = 1'b0;
                     en_in[scan_ff]   = 1'b0;
                  end
               end
               if (scan_last) begin
                  state_in = (pend_in) ? EX_CMD : EX_IDLE;
                  cur_in.op = OP_TICK;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         default: state_in = EX_IDLE;
      endcase
      // final expiry of a tick leaves from the command state with last set
      if (state_ff == EX_CMD && op_type'(cur_ff.op) == OP_TICK) begin
         out_data.kind       = KIND_EXPIRY;
         out_data.status     = ST_OK;
         out_data.timer_slot = 4'(pslot_ff);
         out_data.last       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         en_ff   <= '0;
         per_ff  <= '0;
         now_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         en_ff   <= en_in;
         per_ff  <= per_in;
         now_ff  <= now_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      scan_ff  <= scan_in;
      pslot_ff <= pslot_in;
      if (wr_en) begin
         dl_ff[wr_idx] <= wr_dl;
      end
      if (wr_ival_en) begin
         ival_ff[wr_idx] <= wr_ival;
      end
   end

   property p_take_idle;
      @(posedge clock) disable iff (reset) cmd_take |=> state_ff != EX_IDLE;
   endproperty
   a_take_idle: assert property (p_take_idle) else $error("command lost");

   property p_no_push_full;
      @(posedge clock) disable iff (reset)
         (out_valid && out_full) |-> state_ff == EX_CMD;
   endproperty
   a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

   property p_enabled_used;
      @(posedge clock) disable iff (reset) (en_ff & ~used_ff) == '0;
   endproperty
   a_enabled_used: assert property (p_enabled_used) else $error("enabled slot not in use");
endmodule
`default_nettype wire

// File: design/multi_slot_timer_queue.sv
// top level of the multi-slot timer queue
// a command's result is pushed to the result queue from the command state
// a tick scans one slot per cycle while the result queue can take its expiries,
// and expiries stream during the scan; the engine takes one command or tick at a
// time, only when idle, and waits in the command state while the result queue is full
// reset clears all slots, the time counter and both queues
`default_nettype none
module multi_slot_timer_queue
   import mstq_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);
   req_type cmd;
   logic    cmd_empty, cmd_take, ev_valid, ev_full;
   rsp_type ev_data;

   mstq_fifo #(.WIDTH($bits(req_type)), .DEPTH(2)) u_req_fifo (
      .clock, .reset,
      .push(push), .push_data(req_data), .full(full),
      .pop(cmd_take), .pop_data(cmd), .empty(cmd_empty)
   );

   mstq_engine #(.SLOT_COUNT(SLOT_COUNT), .TIME_WIDTH(TIME_WIDTH)) u_engine (
      .clock, .reset,
      .cmd_valid(!cmd_empty), .cmd(cmd), .cmd_take(cmd_take),
      .out_valid(ev_valid), .out_data(ev_data), .out_full(ev_full)
   );

   mstq_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_fifo (
      .clock, .reset,
      .push(ev_valid), .push_data(ev_data), .full(ev_full),
      .pop(pop), .pop_data(rsp_data), .empty(empty)
   );
endmodule
`default_nettype wire
